// File: src/pcfs_pkg.sv
// shared types and constants of the per-channel fragment statistics block
`timescale 1ns / 1ps

package pcfs_pkg;

    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 32;
    localparam int CNT_BITS  = 32;
    localparam int DEAD_BITS = 16;

    localparam logic [31:0] PACKET_LOW_INIT = 32'h7fff_ffff;

    typedef struct packed {
        logic [3:0]            detector_type;
        logic [9:0]            channel_address;
        logic [ID_BITS-1:0]    trigger_id;
        logic [TIME_BITS-1:0]  fine_timestamp;
        logic [31:0]           packet_number;
        logic [DEAD_BITS-1:0]  dead_time;
        logic [31:0]           coarse_time;
    } frag_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    min_trigger_id;
        logic [ID_BITS-1:0]    max_trigger_id;
        logic [CNT_BITS-1:0]   channel_hits;
        logic [TIME_BITS-1:0]  dead_time_total;
        logic [TIME_BITS-1:0]  min_fine_time;
        logic [TIME_BITS-1:0]  max_fine_time;
        logic [CNT_BITS-1:0]   type_count;
        logic [CNT_BITS-1:0]   packets_seen;
        logic [31:0]           lowest_packet;
        logic [31:0]           highest_packet;
        logic [31:0]           first_coarse_time;
        logic [31:0]           last_coarse_time;
    } stats_t;

    // one row of the channel table
    typedef struct packed {
        logic                  valid;
        logic [ID_BITS-1:0]    min_id;
        logic [ID_BITS-1:0]    max_id;
        logic [CNT_BITS-1:0]   hits;
        logic [TIME_BITS-1:0]  dead_sum;
        logic [TIME_BITS-1:0]  min_time;
        logic [TIME_BITS-1:0]  max_time;
    } chan_entry_t;

endpackage

// File: src/per_channel_fragment_statistics.sv
// top level: channel table, detector type counters and global packet/time statistics
`timescale 1ns / 1ps
// one fragment at a time, taken only while idle; the memories are read in the start cycle and
//   written back in the next, during which busy is high
// done pulses for one cycle, registered from the update state; the receiver cannot stall
// reset: rst_n clears control and global counters, then a clearing pass over all
//   2^max(CHANNEL_ADDR_BITS, TYPE_BITS) addresses (1024 by default) zeroes the memories, busy high

module per_channel_fragment_statistics
#(
    parameter int CHANNEL_ADDR_BITS = 10,
    parameter int TYPE_BITS         = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pcfs_pkg::frag_t frag,
    output logic            done,
    output pcfs_pkg::stats_t stats
);
    import pcfs_pkg::*;

    localparam int CHAN_DEPTH = 1 << CHANNEL_ADDR_BITS;
    localparam int TYPE_DEPTH = 1 << TYPE_BITS;
    localparam int CLR_BITS   = (CHANNEL_ADDR_BITS > TYPE_BITS) ?
                                CHANNEL_ADDR_BITS : TYPE_BITS;

    // sequencer codes
    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CLR_BITS-1:0] clr_cnt_reg, clr_cnt_next;

    // state memories
    chan_entry_t         chan_mem [CHAN_DEPTH];
    logic [CNT_BITS-1:0] type_mem [TYPE_DEPTH];

    chan_entry_t         chan_rdata_reg;
    logic [CNT_BITS-1:0] type_rdata_reg;

    // fragment held through the update cycle
    frag_t               frag_reg;

    // global statistics
    logic [CNT_BITS-1:0] packet_cnt_reg, packet_cnt_next;
    logic [31:0]         packet_low_reg, packet_low_next;
    logic [31:0]         packet_high_reg, packet_high_next;
    logic [31:0]         coarse_low_reg, coarse_low_next;
    logic [31:0]         coarse_high_reg, coarse_high_next;

    logic                done_reg;
    stats_t              stats_reg;

    logic                      accept;
    logic [CHANNEL_ADDR_BITS-1:0] chan_raddr;
    logic [TYPE_BITS-1:0]      type_raddr;
    logic [CHANNEL_ADDR_BITS-1:0] chan_waddr;
    logic [TYPE_BITS-1:0]      type_waddr;
    logic                      mem_we;
    chan_entry_t               chan_wdata;
    logic [CNT_BITS-1:0]       type_wdata;
    chan_entry_t               entry_upd;
    logic [CNT_BITS-1:0]       type_upd;
    logic                      pkt_present;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // upper address bits beyond the table size are ignored
    assign chan_raddr = CHANNEL_ADDR_BITS'(frag.channel_address);
    assign type_raddr = TYPE_BITS'(frag.detector_type);

    pcfs_entry_update u_entry_update
    (
        .old_entry (chan_rdata_reg),
        .frag      (frag_reg),
        .new_entry (entry_upd)
    );

    assign type_upd = (&type_rdata_reg) ? type_rdata_reg : type_rdata_reg + CNT_BITS'(1);

    // write port: clearing sweep after reset, otherwise write-back of the update cycle
    always_comb
    begin
        mem_we     = 1'b0;
        chan_waddr = CHANNEL_ADDR_BITS'(frag_reg.channel_address);
        type_waddr = TYPE_BITS'(frag_reg.detector_type);
        chan_wdata = entry_upd;
        type_wdata = type_upd;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                chan_waddr = clr_cnt_reg[CHANNEL_ADDR_BITS-1:0];
                type_waddr = clr_cnt_reg[TYPE_BITS-1:0];
                chan_wdata = '0;
                type_wdata = '0;
            end
            ST_UPDATE:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            chan_mem[chan_waddr] <= chan_wdata;
            type_mem[type_waddr] <= type_wdata;
        end
        chan_rdata_reg <= chan_mem[chan_raddr];
        type_rdata_reg <= type_mem[type_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CLR_BITS'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // global packet and coarse time statistics
    assign pkt_present = (frag_reg.packet_number != 32'd0);

    always_comb
    begin
        packet_cnt_next  = packet_cnt_reg;
        packet_low_next  = packet_low_reg;
        packet_high_next = packet_high_reg;
        if (pkt_present)
        begin
            packet_cnt_next = (&packet_cnt_reg) ? packet_cnt_reg :
                              packet_cnt_reg + CNT_BITS'(1);
            if (frag_reg.packet_number < packet_low_reg)
            begin
                packet_low_next = frag_reg.packet_number;
            end
            if (frag_reg.packet_number > packet_high_reg)
            begin
                packet_high_next = frag_reg.packet_number;
            end
        end
        // zero marks an unset coarse bound, so it is always replaced
        coarse_low_next  = (coarse_low_reg == 32'd0 || frag_reg.coarse_time < coarse_low_reg) ?
                           frag_reg.coarse_time : coarse_low_reg;
        coarse_high_next = (coarse_high_reg == 32'd0 || frag_reg.coarse_time > coarse_high_reg) ?
                           frag_reg.coarse_time : coarse_high_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            packet_cnt_reg  <= '0;
            packet_low_reg  <= PACKET_LOW_INIT;
            packet_high_reg <= '0;
            coarse_low_reg  <= '0;
            coarse_high_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == ST_UPDATE);
            if (state_reg == ST_UPDATE)
            begin
                packet_cnt_reg  <= packet_cnt_next;
                packet_low_reg  <= packet_low_next;
                packet_high_reg <= packet_high_next;
                coarse_low_reg  <= coarse_low_next;
                coarse_high_reg <= coarse_high_next;
            end
        end
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frag_reg <= frag;
        end
        if (state_reg == ST_UPDATE)
        begin
            stats_reg.min_trigger_id    <= entry_upd.min_id;
            stats_reg.max_trigger_id    <= entry_upd.max_id;
            stats_reg.channel_hits      <= entry_upd.hits;
            stats_reg.dead_time_total   <= entry_upd.dead_sum;
            stats_reg.min_fine_time     <= entry_upd.min_time;
            stats_reg.max_fine_time     <= entry_upd.max_time;
            stats_reg.type_count        <= type_upd;
            stats_reg.packets_seen      <= packet_cnt_next;
            stats_reg.lowest_packet     <= packet_low_next;
            stats_reg.highest_packet    <= packet_high_next;
            stats_reg.first_coarse_time <= coarse_low_next;
            stats_reg.last_coarse_time  <= coarse_high_next;
        end
    end

    assign done  = done_reg;
    assign stats = stats_reg;

endmodule

// File: src/pcfs_entry_update.sv
// merge of one fragment into a channel table row
`timescale 1ns / 1ps

module pcfs_entry_update
(
    input  pcfs_pkg::chan_entry_t old_entry,
    input  pcfs_pkg::frag_t       frag,
    output pcfs_pkg::chan_entry_t new_entry
);
    import pcfs_pkg::*;

    logic [TIME_BITS:0] dead_sum_wide;

    assign dead_sum_wide = {1'b0, old_entry.dead_sum}
                         + {{(TIME_BITS+1-DEAD_BITS){1'b0}}, frag.dead_time};

    always_comb
    begin
        new_entry.valid = 1'b1;
        if (!old_entry.valid)
        begin
            // first hit on this channel seeds the row
            new_entry.min_id   = frag.trigger_id;
            new_entry.max_id   = frag.trigger_id;
            new_entry.hits     = CNT_BITS'(1);
            new_entry.dead_sum = {{(TIME_BITS-DEAD_BITS){1'b0}}, frag.dead_time};
            new_entry.min_time = frag.fine_timestamp;
            new_entry.max_time = frag.fine_timestamp;
        end
        else
        begin
            new_entry.min_id = (frag.trigger_id < old_entry.min_id) ?
                               frag.trigger_id : old_entry.min_id;
            new_entry.max_id = (frag.trigger_id > old_entry.max_id) ?
                               frag.trigger_id : old_entry.max_id;
            new_entry.hits   = (&old_entry.hits) ? old_entry.hits :
                               old_entry.hits + CNT_BITS'(1);
            new_entry.dead_sum = dead_sum_wide[TIME_BITS] ? {TIME_BITS{1'b1}} :
                                 dead_sum_wide[TIME_BITS-1:0];
            new_entry.min_time = (frag.fine_timestamp < old_entry.min_time) ?
                                 frag.fine_timestamp : old_entry.min_time;
            new_entry.max_time = (frag.fine_timestamp > old_entry.max_time) ?
                                 frag.fine_timestamp : old_entry.max_time;
        end
    end

endmodule

// File: verif/tb_per_channel_fragment_statistics.sv
// self-checking testbench for the per-channel fragment statistics block
`timescale 1ns / 1ps

module tb_per_channel_fragment_statistics;

    import pcfs_pkg::*;

    // run shape
    localparam int CHAN_DEPTH   = 1024;
    localparam int TYPE_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1900;
    // slowest correct run: reset, the clearing pass, then per fragment the busy time of
    // the block plus the longest idle burst; this limit is several times that
    localparam int LIMIT_CYCLES = 200000;
    localparam int PRINT_LIMIT  = 50;

    localparam logic [47:0] TIME_MAX = 48'hffff_ffff_ffff;
    localparam logic [31:0] WORD_MAX = 32'hffff_ffff;

    // one row of the directed table; want is used only where typed is set
    typedef struct {
        frag_t  frag;
        bit     typed;
        stats_t want;
    } directed_row_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    frag_t  frag;
    logic   done;
    stats_t stats;

    // side band of the fragment being offered, changes with it at the falling edge
    bit     row_typed;
    stats_t row_want;

    // predictor copy of the channel table
    bit          chan_valid   [CHAN_DEPTH];
    logic [31:0] chan_min_id  [CHAN_DEPTH];
    logic [31:0] chan_max_id  [CHAN_DEPTH];
    logic [31:0] chan_hits    [CHAN_DEPTH];
    logic [47:0] chan_dead    [CHAN_DEPTH];
    logic [47:0] chan_min_time[CHAN_DEPTH];
    logic [47:0] chan_max_time[CHAN_DEPTH];

    // predictor copy of the per-type counters and global statistics
    logic [31:0] type_totals[TYPE_DEPTH];
    logic [31:0] packet_total;
    logic [31:0] packet_floor;
    logic [31:0] packet_ceiling;
    logic [31:0] coarse_first;
    logic [31:0] coarse_last;

    // statistics expected from the block, oldest first
    stats_t pending_stats[$];
    stats_t predicted;
    stats_t oldest;

    int error_count;
    int sent_count;
    int checked_count;

    // a handful of channels that collect most random hits so entries grow deep
    int hot_channels[8] = '{0, 1, 2, 511, 512, 513, 1022, 1023};

    per_channel_fragment_statistics u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .frag  (frag),
        .done  (done),
        .stats (stats)
    );

    // free-running 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 LIMIT_CYCLES, pending_stats.size());
        $display("tb_per_channel_fragment_statistics: done, errors");
        $finish;
    end

    // one line per mismatch, quiet after the first few dozen
    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0d ns: %s", $time, msg);
    endtask

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == WORD_MAX) ? v : v + 32'd1;
    endfunction

    function automatic frag_t make_frag(logic [3:0] dtype, logic [9:0] addr,
                                        logic [31:0] id, logic [47:0] ts,
                                        logic [31:0] pkt, logic [15:0] dead,
                                        logic [31:0] coarse);
        frag_t f;
        f.detector_type   = dtype;
        f.channel_address = addr;
        f.trigger_id      = id;
        f.fine_timestamp  = ts;
        f.packet_number   = pkt;
        f.dead_time       = dead;
        f.coarse_time     = coarse;
        return f;
    endfunction

    function automatic stats_t make_stats(logic [31:0] min_id, logic [31:0] max_id,
                                          logic [31:0] hits, logic [47:0] dead,
                                          logic [47:0] min_t, logic [47:0] max_t,
                                          logic [31:0] tcount, logic [31:0] pkts,
                                          logic [31:0] pkt_lo, logic [31:0] pkt_hi,
                                          logic [31:0] c_lo, logic [31:0] c_hi);
        stats_t s;
        s.min_trigger_id    = min_id;
        s.max_trigger_id    = max_id;
        s.channel_hits      = hits;
        s.dead_time_total   = dead;
        s.min_fine_time     = min_t;
        s.max_fine_time     = max_t;
        s.type_count        = tcount;
        s.packets_seen      = pkts;
        s.lowest_packet     = pkt_lo;
        s.highest_packet    = pkt_hi;
        s.first_coarse_time = c_lo;
        s.last_coarse_time  = c_hi;
        return s;
    endfunction

    // state right after reset; unwritten entries are never read, zero is arbitrary
    task automatic clear_statistics();
        for (int i = 0; i < CHAN_DEPTH; i++)
        begin
            chan_valid[i]    = 1'b0;
            chan_min_id[i]   = '0;
            chan_max_id[i]   = '0;
            chan_hits[i]     = '0;
            chan_dead[i]     = '0;
            chan_min_time[i] = '0;
            chan_max_time[i] = '0;
        end
        for (int i = 0; i < TYPE_DEPTH; i++)
            type_totals[i] = '0;
        packet_total   = '0;
        packet_floor   = PACKET_LOW_INIT;
        packet_ceiling = '0;
        coarse_first   = '0;
        coarse_last    = '0;
    endtask

    // apply one fragment to the predictor state and return the updated statistics
    function automatic stats_t update_statistics(frag_t f);
        stats_t      s;
        logic [9:0]  a;
        logic [3:0]  t;
        logic [48:0] sum;
        a = f.channel_address;
        t = f.detector_type;

        type_totals[t] = sat_inc(type_totals[t]);

        if (!chan_valid[a])
        begin
            // first hit seeds the entry
            chan_valid[a]    = 1'b1;
            chan_min_id[a]   = f.trigger_id;
            chan_max_id[a]   = f.trigger_id;
            chan_hits[a]     = 32'd1;
            chan_dead[a]     = {32'd0, f.dead_time};
            chan_min_time[a] = f.fine_timestamp;
            chan_max_time[a] = f.fine_timestamp;
        end
        else
        begin
            sum = {1'b0, chan_dead[a]} + {33'd0, f.dead_time};
            if (f.trigger_id < chan_min_id[a])
                chan_min_id[a] = f.trigger_id;
            if (f.trigger_id > chan_max_id[a])
                chan_max_id[a] = f.trigger_id;
            chan_hits[a] = sat_inc(chan_hits[a]);
            chan_dead[a] = sum[48] ? TIME_MAX : sum[47:0];
            if (f.fine_timestamp < chan_min_time[a])
                chan_min_time[a] = f.fine_timestamp;
            if (f.fine_timestamp > chan_max_time[a])
                chan_max_time[a] = f.fine_timestamp;
        end

        // packet number zero means no packet
        if (f.packet_number != 32'd0)
        begin
            packet_total = sat_inc(packet_total);
            if (f.packet_number < packet_floor)
                packet_floor = f.packet_number;
            if (f.packet_number > packet_ceiling)
                packet_ceiling = f.packet_number;
        end

        // zero marks the coarse bounds as unset, so they get overwritten
        if (coarse_first == 32'd0 || f.coarse_time < coarse_first)
            coarse_first = f.coarse_time;
        if (coarse_last == 32'd0 || f.coarse_time > coarse_last)
            coarse_last = f.coarse_time;

        s = make_stats(chan_min_id[a], chan_max_id[a], chan_hits[a], chan_dead[a],
                       chan_min_time[a], chan_max_time[a], type_totals[t],
                       packet_total, packet_floor, packet_ceiling,
                       coarse_first, coarse_last);
        return s;
    endfunction

    function automatic frag_t random_fragment();
        logic [9:0]  addr;
        logic [31:0] id;
        logic [63:0] wide;
        logic [47:0] ts;
        logic [31:0] pkt;
        logic [15:0] dead;
        logic [31:0] coarse;

        // most hits land on a few hot channels
        if ($urandom_range(0, 9) < 6)
            addr = 10'(hot_channels[$urandom_range(0, 7)]);
        else
            addr = 10'($urandom_range(0, CHAN_DEPTH - 1));

        case ($urandom_range(0, 3))
            0: id = $urandom_range(0, 255);
            1: id = 32'hffff_ff00 | $urandom_range(0, 255);
            default: id = $urandom;
        endcase

        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ts = {36'd0, wide[11:0]};
            1: ts = TIME_MAX - {36'd0, wide[11:0]};
            default: ts = wide[47:0];
        endcase

        // packet numbers cluster around zero, small values and the 0x7fffffff boundary
        case ($urandom_range(0, 5))
            0, 1: pkt = 32'd0;
            2: pkt = $urandom_range(1, 1000);
            3: pkt = PACKET_LOW_INIT - 32'd256 + $urandom_range(0, 511);
            default: pkt = $urandom;
        endcase

        dead = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 65535));

        case ($urandom_range(0, 6))
            0: coarse = 32'd0;
            1: coarse = $urandom_range(1, 100);
            default: coarse = $urandom;
        endcase

        return make_frag(4'($urandom_range(0, TYPE_DEPTH - 1)), addr, id, ts, pkt,
                         dead, coarse);
    endfunction

    // offer one fragment and hold it until the block takes it
    task automatic send_fragment(frag_t f, bit typed, stats_t want);
        start     <= 1'b1;
        frag      <= f;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // start low for a burst of cycles
    task automatic idle_burst(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic check_statistics(stats_t got, stats_t want);
        if (got.min_trigger_id !== want.min_trigger_id)
            report_mismatch($sformatf("result %0d min_trigger_id got %h want %h",
                            checked_count, got.min_trigger_id, want.min_trigger_id));
        if (got.max_trigger_id !== want.max_trigger_id)
            report_mismatch($sformatf("result %0d max_trigger_id got %h want %h",
                            checked_count, got.max_trigger_id, want.max_trigger_id));
        if (got.channel_hits !== want.channel_hits)
            report_mismatch($sformatf("result %0d channel_hits got %h want %h",
                            checked_count, got.channel_hits, want.channel_hits));
        if (got.dead_time_total !== want.dead_time_total)
            report_mismatch($sformatf("result %0d dead_time_total got %h want %h",
                            checked_count, got.dead_time_total, want.dead_time_total));
        if (got.min_fine_time !== want.min_fine_time)
            report_mismatch($sformatf("result %0d min_fine_time got %h want %h",
                            checked_count, got.min_fine_time, want.min_fine_time));
        if (got.max_fine_time !== want.max_fine_time)
            report_mismatch($sformatf("result %0d max_fine_time got %h want %h",
                            checked_count, got.max_fine_time, want.max_fine_time));
        if (got.type_count !== want.type_count)
            report_mismatch($sformatf("result %0d type_count got %h want %h",
                            checked_count, got.type_count, want.type_count));
        if (got.packets_seen !== want.packets_seen)
            report_mismatch($sformatf("result %0d packets_seen got %h want %h",
                            checked_count, got.packets_seen, want.packets_seen));
        if (got.lowest_packet !== want.lowest_packet)
            report_mismatch($sformatf("result %0d lowest_packet got %h want %h",
                            checked_count, got.lowest_packet, want.lowest_packet));
        if (got.highest_packet !== want.highest_packet)
            report_mismatch($sformatf("result %0d highest_packet got %h want %h",
                            checked_count, got.highest_packet, want.highest_packet));
        if (got.first_coarse_time !== want.first_coarse_time)
            report_mismatch($sformatf("result %0d first_coarse_time got %h want %h",
                            checked_count, got.first_coarse_time, want.first_coarse_time));
        if (got.last_coarse_time !== want.last_coarse_time)
            report_mismatch($sformatf("result %0d last_coarse_time got %h want %h",
                            checked_count, got.last_coarse_time, want.last_coarse_time));
    endtask

    // watch both sides at the rising edge: check a finished transfer first, then
    // record an accepted fragment; values read here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_stats.size() == 0)
                    report_mismatch("result with no fragment outstanding");
                else
                begin
                    oldest = pending_stats.pop_front();
                    check_statistics(stats, oldest);
                end
                checked_count++;
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                // predictor always runs so its state follows every accepted fragment
                predicted = update_statistics(frag);
                pending_stats.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    initial
    begin
        directed_row_t table_rows[$];
        stats_t        none;
        int            quiet_from;
        int            touched;

        rst_n       = 1'b0;
        start       = 1'b0;
        frag        = '0;
        row_typed   = 1'b0;
        row_want    = '0;
        none        = '0;
        error_count = 0;
        sent_count  = 0;
        checked_count = 0;
        clear_statistics();

        // directed table: fresh state, extremes, repeats on one channel,
        // the packet-number boundary at 0x7fffffff and coarse time zero
        table_rows.push_back('{make_frag(4'd0, 10'd0, 32'd0, 48'd0, 32'd0, 16'd0, 32'd0),
            1'b1, make_stats(32'd0, 32'd0, 32'd1, 48'd0, 48'd0, 48'd0,
                             32'd1, 32'd0, PACKET_LOW_INIT, 32'd0, 32'd0, 32'd0)});
        // all-ones fragment; packet 0xffffffff is counted but cannot lower the floor
        table_rows.push_back('{make_frag(4'd15, 10'd1023, WORD_MAX, TIME_MAX, WORD_MAX,
                                         16'hffff, WORD_MAX),
            1'b1, make_stats(WORD_MAX, WORD_MAX, 32'd1, 48'h00ffff, TIME_MAX, TIME_MAX,
                             32'd1, 32'd1, PACKET_LOW_INIT, WORD_MAX, WORD_MAX, WORD_MAX)});
        // second hit: packet exactly at the initial floor leaves it alone
        table_rows.push_back('{make_frag(4'd15, 10'd1023, 32'd0, 48'd0, PACKET_LOW_INIT,
                                         16'hffff, 32'd1),
            1'b1, make_stats(32'd0, WORD_MAX, 32'd2, 48'h01fffe, 48'd0, TIME_MAX,
                             32'd2, 32'd2, PACKET_LOW_INIT, WORD_MAX, 32'd1, WORD_MAX)});
        // one below the floor lowers it; coarse zero clears the first coarse time
        table_rows.push_back('{make_frag(4'd0, 10'd1023, 32'd5, 48'd5, 32'h7fff_fffe,
                                         16'd0, 32'd0),
            1'b1, make_stats(32'd0, WORD_MAX, 32'd3, 48'h01fffe, 48'd0, TIME_MAX,
                             32'd2, 32'd3, 32'h7fff_fffe, WORD_MAX, 32'd0, WORD_MAX)});
        // unset first coarse time is overwritten, no packet
        table_rows.push_back('{make_frag(4'd1, 10'd0, WORD_MAX, TIME_MAX, 32'd0,
                                         16'hffff, 32'd7),
            1'b1, make_stats(32'd0, WORD_MAX, 32'd2, 48'h00ffff, 48'd0, TIME_MAX,
                             32'd1, 32'd3, 32'h7fff_fffe, WORD_MAX, 32'd7, WORD_MAX)});
        // alternating bit patterns on the remaining fields, then min/max updates
        table_rows.push_back('{make_frag(4'd8, 10'd512, 32'h5555_5555, 48'haaaa_aaaa_aaaa,
                                         32'd1, 16'h5555, 32'haaaa_aaaa), 1'b0, none});
        table_rows.push_back('{make_frag(4'd7, 10'd511, 32'haaaa_aaaa, 48'h5555_5555_5555,
                                         32'h8000_0000, 16'haaaa, 32'h5555_5555), 1'b0, none});
        table_rows.push_back('{make_frag(4'd8, 10'd512, 32'h5555_5554, 48'haaaa_aaaa_aaab,
                                         32'd2, 16'h0001, 32'h0000_0003), 1'b0, none});
        table_rows.push_back('{make_frag(4'd9, 10'd512, 32'h5555_5556, 48'haaaa_aaaa_aaa9,
                                         32'd0, 16'hffff, 32'hffff_fffe), 1'b0, none});
        table_rows.push_back('{make_frag(4'd2, 10'd1, 32'd100, 48'd1000, 32'd0,
                                         16'd10, 32'd0), 1'b0, none});
        table_rows.push_back('{make_frag(4'd2, 10'd1, 32'd100, 48'd1000, 32'd3,
                                         16'd10, 32'd2), 1'b0, none});
        table_rows.push_back('{make_frag(4'd4, 10'd0, 32'd1, 48'd1, 32'h7fff_ffff,
                                         16'd0, 32'd5), 1'b0, none});
        table_rows.push_back('{make_frag(4'd15, 10'd1023, 32'h8000_0000, 48'h8000_0000_0000,
                                         WORD_MAX, 16'hffff, WORD_MAX), 1'b0, none});
        table_rows.push_back('{make_frag(4'd15, 10'd1023, 32'h7fff_ffff, 48'h7fff_ffff_ffff,
                                         32'd0, 16'hffff, 32'd1), 1'b0, none});

        // reset held low from the start, released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset keeps busy high; the handshake absorbs it
        foreach (table_rows[i])
        begin
            send_fragment(table_rows[i].frag, table_rows[i].typed, table_rows[i].want);
            if ($urandom_range(0, 2) == 0)
                idle_burst($urandom_range(1, 11));
        end

        // random part, with no idling in the last stretch
        quiet_from = RANDOM_ITEMS * 85 / 100;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_fragment(random_fragment(), 1'b0, none);
            if (n < quiet_from && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 11));
        end
        start <= 1'b0;

        // drain outstanding results, then keep watching for strays
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        touched = 0;
        foreach (chan_valid[i])
            if (chan_valid[i])
                touched++;
        $display("%0d fragments sent (%0d from the directed table), %0d results compared",
                 sent_count, table_rows.size(), checked_count);
        $display("%0d channel entries written, %0d packets counted, %0d mismatches",
                 touched, packet_total, error_count);

        if (error_count == 0)
            $display("tb_per_channel_fragment_statistics: done, clean");
        else
            $display("tb_per_channel_fragment_statistics: done, errors");
        $finish;
    end

endmodule

// File: files.f
src/pcfs_pkg.sv
src/pcfs_entry_update.sv
src/per_channel_fragment_statistics.sv
verif/tb_per_channel_fragment_statistics.sv
